>>> hw/rtl/aso_pkg.sv
package aso_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FormW = 3;

  typedef enum logic [FormW-1:0] {
    FORM_IMM_SHIFT = 3'd0,
    FORM_REG_SHIFT = 3'd1,
    FORM_ROT_IMM   = 3'd2,
    FORM_LS_IMM    = 3'd3,
    FORM_LS_SCALED = 3'd4,
    FORM_NONE      = 3'd5
  } form_t;

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_kind_t;

  // instruction class codes in bits 27:25
  localparam logic [2:0] ClassDataShift = 3'b000;
  localparam logic [2:0] ClassDataImm   = 3'b001;
  localparam logic [2:0] ClassLsImm     = 3'b010;
  localparam logic [2:0] ClassLsReg     = 3'b011;

  localparam logic [7:0] RegAmtFull = 8'd32;

  typedef struct packed {
    logic [WordW-1:0] instr;
    logic [WordW-1:0] rm_value;
    logic [WordW-1:0] rs_value;
    logic             carry_in;
  } req_item_t;

  typedef struct packed {
    logic [WordW-1:0] operand;
    logic             carry_out;
    logic [FormW-1:0] form;
  } rsp_item_t;

endpackage

>>> hw/rtl/aso_stream_if.sv
interface aso_req_if;
  import aso_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aso_rsp_if;
  import aso_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/aso_shift_core.sv
module aso_shift_core (
  input  aso_pkg::req_item_t item,
  output aso_pkg::rsp_item_t result
);
  import aso_pkg::*;

  logic [WordW-1:0] instr;
  logic [WordW-1:0] rm;
  logic             cin;
  logic [2:0]       cls;
  shift_kind_t      kind;
  logic [4:0]       imm_amt;
  logic [7:0]       reg_amt;
  logic [4:0]       n;
  logic             top;

  // generic shifts by n in 1..31
  logic [WordW:0]     lsl_ext;
  logic [WordW:0]     rsh_ext;
  logic [2*WordW-1:0] ror_ext;
  logic [WordW-1:0]   asr_res;
  logic [WordW-1:0]   sign_fill;

  // rotated immediate
  logic [4:0]         rot;
  logic [2*WordW-1:0] rimm_ext;
  logic [WordW-1:0]   rimm_res;

  logic [WordW-1:0] imm_res;
  logic             imm_c;
  logic [WordW-1:0] reg_res;
  logic             reg_c;

  assign instr   = item.instr;
  assign rm      = item.rm_value;
  assign cin     = item.carry_in;
  assign cls     = instr[27:25];
  assign kind    = shift_kind_t'(instr[6:5]);
  assign imm_amt = instr[11:7];
  assign reg_amt = item.rs_value[7:0];
  assign top     = rm[WordW-1];
  assign sign_fill = {WordW{top}};

  // register form uses only the low five bits below 32 or for rotation
  assign n = (cls == ClassDataShift && instr[4]) ? reg_amt[4:0] : imm_amt;

  assign lsl_ext = {1'b0, rm} << n;
  assign rsh_ext = {rm, 1'b0} >> n;
  assign ror_ext = {rm, rm} >> n;
  assign asr_res = WordW'($signed(rm) >>> n);

  assign rot      = {instr[11:8], 1'b0};
  assign rimm_ext = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> rot;
  assign rimm_res = rimm_ext[WordW-1:0];

  // immediate-shift rules, zero amount encodes the special cases
  always_comb begin
    imm_res = rm;
    imm_c   = cin;
    if (imm_amt == '0) begin
      unique case (kind)
        SHIFT_LSL: begin imm_res = rm;                 imm_c = cin;   end
        SHIFT_LSR: begin imm_res = '0;                 imm_c = top;   end
        SHIFT_ASR: begin imm_res = sign_fill;          imm_c = top;   end
        SHIFT_ROR: begin imm_res = {cin, rm[WordW-1:1]}; imm_c = rm[0]; end
        default:   begin imm_res = rm;                 imm_c = cin;   end
      endcase
    end else begin
      unique case (kind)
        SHIFT_LSL: begin imm_res = lsl_ext[WordW-1:0]; imm_c = lsl_ext[WordW]; end
        SHIFT_LSR: begin imm_res = rsh_ext[WordW:1];   imm_c = rsh_ext[0];     end
        SHIFT_ASR: begin imm_res = asr_res;            imm_c = rsh_ext[0];     end
        SHIFT_ROR: begin imm_res = ror_ext[WordW-1:0]; imm_c = rsh_ext[0];     end
        default:   begin imm_res = rm;                 imm_c = cin;            end
      endcase
    end
  end

  // register-shift rules, amount taken from the low byte of rs
  always_comb begin
    reg_res = rm;
    reg_c   = cin;
    if (reg_amt != '0) begin
      unique case (kind)
        SHIFT_LSL: begin
          if (reg_amt < RegAmtFull) begin
            reg_res = lsl_ext[WordW-1:0];
            reg_c   = lsl_ext[WordW];
          end else begin
            reg_res = '0;
            reg_c   = (reg_amt == RegAmtFull) ? rm[0] : 1'b0;
          end
        end
        SHIFT_LSR: begin
          if (reg_amt < RegAmtFull) begin
            reg_res = rsh_ext[WordW:1];
            reg_c   = rsh_ext[0];
          end else begin
            reg_res = '0;
            reg_c   = (reg_amt == RegAmtFull) ? top : 1'b0;
          end
        end
        SHIFT_ASR: begin
          if (reg_amt < RegAmtFull) begin
            reg_res = asr_res;
            reg_c   = rsh_ext[0];
          end else begin
            reg_res = sign_fill;
            reg_c   = top;
          end
        end
        SHIFT_ROR: begin
          if (reg_amt[4:0] == '0) begin
            reg_res = rm;
            reg_c   = top;
          end else begin
            reg_res = ror_ext[WordW-1:0];
            reg_c   = rsh_ext[0];
          end
        end
        default: begin
          reg_res = rm;
          reg_c   = cin;
        end
      endcase
    end
  end

  always_comb begin
    result.operand   = '0;
    result.carry_out = cin;
    result.form      = FORM_NONE;
    priority if (cls == ClassDataShift && !instr[4]) begin
      result.operand   = imm_res;
      result.carry_out = imm_c;
      result.form      = FORM_IMM_SHIFT;
    end else if (cls == ClassDataShift && !instr[7]) begin
      result.operand   = reg_res;
      result.carry_out = reg_c;
      result.form      = FORM_REG_SHIFT;
    end else if (cls == ClassDataImm) begin
      result.operand   = rimm_res;
      result.carry_out = (rot != '0) ? rimm_res[WordW-1] : cin;
      result.form      = FORM_ROT_IMM;
    end else if (cls == ClassLsImm) begin
      result.operand   = {20'd0, instr[11:0]};
      result.form      = FORM_LS_IMM;
    end else if (cls == ClassLsReg && !instr[4]) begin
      // address offset leaves the flags alone
      result.operand   = imm_res;
      result.form      = FORM_LS_SCALED;
    end else begin
      result.form      = FORM_NONE;
    end
  end

endmodule

>>> hw/rtl/arm_shifter_operand_unit.sv
// channel | dir | payload                                    | handshake
// req     | in  | instr, rm_value, rs_value, carry_in        | valid / ready
// rsp     | out | operand, carry_out, form                   | valid / ready
//
// one transaction per cycle sustained while rsp is ready; each passes from req to rsp
// through the input register and then the result register around the shifter
// rst is synchronous and clears both valid flags, payload registers hold no reset
// a stalled rsp holds its result; req keeps accepting while the input stage can move
// or is empty, so one transaction can sit in each stage during a stall
module arm_shifter_operand_unit (
  input logic   clk,
  input logic   rst,
  aso_req_if.sink   req,
  aso_rsp_if.source rsp
);
  import aso_pkg::*;

  // input stage
  logic      s1_valid;
  req_item_t s1_item;

  // result stage
  logic      out_valid;
  rsp_item_t out_item;

  rsp_item_t core_result;
  logic      advance;

  // result register can take a new value when empty or being drained
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.ready) begin
      s1_item <= req.payload;
    end
  end

  // shifter and operand decode between the two registers
  aso_shift_core u_core (
    .item   (s1_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_item <= core_result;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !rsp.valid)
    else $error("result valid after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("input taken while both stages are held");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> rsp.valid)
    else $error("input stage advanced but no result appeared");

  a_ls_imm_width: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.form == FORM_LS_IMM) |-> (rsp.payload.operand[31:12] == '0))
    else $error("load/store immediate offset wider than 12 bits");
`endif

endmodule
